@@ src/intra_prediction_residual_unit_assert.svh @@
// Assertion macros used by the intra prediction residual unit RTL.
`ifndef INTRA_PREDICTION_RESIDUAL_UNIT_ASSERT_SVH
`define INTRA_PREDICTION_RESIDUAL_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IPR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IPR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ipr_pkg.sv @@
// Shared types and constants for the intra prediction residual unit.
package ipr_pkg;

    localparam int SIZE_DEF   = 16;
    localparam int ACTION_W   = 2;
    localparam int IDX_W      = 5;
    localparam int POS_W      = 4;
    localparam int SAMPLE_W   = 9;
    localparam int VALUE_W    = 9;
    localparam int SSD_W      = 24;
    localparam int PIX_W      = 8;
    localparam int SQ_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [PIX_W-1:0] REF_MISSING = 8'd128;
    localparam logic [PIX_W-1:0] PIX_MAX     = 8'd255;
    localparam logic [SSD_W-1:0] SSD_MAX     = 24'hFFFFFF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_TOP  = 2'd0,
        ACT_LOAD_LEFT = 2'd1,
        ACT_PREDICT   = 2'd2,
        ACT_RECON     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_VERT = 2'd0,
        MODE_HORZ = 2'd1,
        MODE_AVG  = 2'd2,
        MODE_DIAG = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 2'd0,
        CFG_TOP_AVAIL  = 2'd1,
        CFG_LEFT_AVAIL = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PSEL_TOP  = 2'd0,
        PSEL_LEFT = 2'd1,
        PSEL_AVG  = 2'd2
    } pred_sel_t;

    // Per-pixel control carried from the lookup stage to the arithmetic stage.
    typedef struct packed {
        logic      recon;
        logic      first;
        logic      last;
        pred_sel_t sel;
        logic      top_ok;
        logic      left_ok;
    } pix_ctl_t;

endpackage

@@ src/ipr_channels.sv @@
// Handshake channel interfaces: pixel requests, results, configuration writes.
interface ipr_pix_if import ipr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [IDX_W-1:0]           ref_index;
    logic [POS_W-1:0]           row;
    logic [POS_W-1:0]           col;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first;
    logic                       last;

    modport source (output valid, action, ref_index, row, col, sample, first, last,
                    input ready);
    modport sink   (input valid, action, ref_index, row, col, sample, first, last,
                    output ready);
endinterface

interface ipr_res_if import ipr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [SSD_W-1:0]          ssd;
    logic                      ssd_valid;

    modport source (output valid, value, ssd, ssd_valid, input ready);
    modport sink   (input valid, value, ssd, ssd_valid, output ready);
endinterface

interface ipr_cfg_if import ipr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/ipr_ref_store.sv @@
// Top reference row and left reference column memories with registered reads.
module ipr_ref_store import ipr_pkg::*; #(
    parameter int SIZE = SIZE_DEF,
    localparam int TAW = $clog2(SIZE + 1),
    localparam int LAW = $clog2(SIZE)
) (
    input  logic             clk,
    input  logic             top_we,
    input  logic             left_we,
    input  logic [TAW-1:0]   wr_top_addr,
    input  logic [LAW-1:0]   wr_left_addr,
    input  logic [PIX_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [TAW-1:0]   rd_top_addr,
    input  logic [LAW-1:0]   rd_left_addr,
    output logic [PIX_W-1:0] rd_top,
    output logic [PIX_W-1:0] rd_left
);

    logic [PIX_W-1:0] top_mem [SIZE+1];
    logic [PIX_W-1:0] left_mem [SIZE];
    logic [PIX_W-1:0] rd_top_reg;
    logic [PIX_W-1:0] rd_left_reg;

    always_ff @(posedge clk)
    begin
        if (top_we)
        begin
            top_mem[wr_top_addr] <= wr_data;
        end
        if (left_we)
        begin
            left_mem[wr_left_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_top_reg  <= top_mem[rd_top_addr];
            rd_left_reg <= left_mem[rd_left_addr];
        end
    end

    assign rd_top  = rd_top_reg;
    assign rd_left = rd_left_reg;

endmodule

@@ src/ipr_pix_calc.sv @@
// Prediction, residual or reconstruction, and saturating squared-error sum.
module ipr_pix_calc import ipr_pkg::*; (
    input  pix_ctl_t                   ctl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [PIX_W-1:0]           rd_top,
    input  logic [PIX_W-1:0]           rd_left,
    input  logic [SSD_W-1:0]           ssd_sum,
    output logic signed [VALUE_W-1:0]  value,
    output logic [SSD_W-1:0]           ssd,
    output logic                       ssd_valid,
    output logic [SSD_W-1:0]           ssd_next
);

    logic [PIX_W-1:0]         t_val;
    logic [PIX_W-1:0]         l_val;
    logic [PIX_W:0]           tl_sum;
    logic [PIX_W-1:0]         pred;
    logic signed [VALUE_W:0]  samp_x;
    logic signed [VALUE_W:0]  pred_x;
    logic signed [VALUE_W:0]  diff;
    logic signed [VALUE_W:0]  recon_sum;
    logic signed [VALUE_W-1:0] resid;
    logic signed [VALUE_W-1:0] recon;
    logic signed [2*VALUE_W-1:0] prod;
    logic [SQ_W-1:0]          sq;
    logic [SSD_W-1:0]         base;
    logic [SSD_W:0]           acc;

    // Missing references read as mid-gray.
    assign t_val  = ctl.top_ok  ? rd_top  : REF_MISSING;
    assign l_val  = ctl.left_ok ? rd_left : REF_MISSING;
    assign tl_sum = {1'b0, t_val} + {1'b0, l_val};

    always_comb
    begin
        case (ctl.sel)
            PSEL_TOP:  pred = t_val;
            PSEL_LEFT: pred = l_val;
            PSEL_AVG:  pred = tl_sum[PIX_W:1];
            default:   pred = REF_MISSING;
        endcase
    end

    assign samp_x    = {sample[SAMPLE_W-1], sample};
    assign pred_x    = {2'b00, pred};
    assign diff      = samp_x - pred_x;
    assign recon_sum = samp_x + pred_x;

    // Residual saturates at -255; it cannot exceed +255.
    always_comb
    begin
        if (diff < -10'sd255)
        begin
            resid = -9'sd255;
        end
        else
        begin
            resid = diff[VALUE_W-1:0];
        end
    end

    always_comb
    begin
        if (recon_sum < 10'sd0)
        begin
            recon = '0;
        end
        else if (recon_sum > 10'sd255)
        begin
            recon = {1'b0, PIX_MAX};
        end
        else
        begin
            recon = recon_sum[VALUE_W-1:0];
        end
    end

    assign prod = resid * resid;
    assign sq   = prod[SQ_W-1:0];
    assign base = ctl.first ? '0 : ssd_sum;
    assign acc  = {1'b0, base} + (SSD_W+1)'(sq);

    assign ssd_next  = acc[SSD_W] ? SSD_MAX : acc[SSD_W-1:0];
    assign value     = ctl.recon ? recon : resid;
    assign ssd       = ctl.recon ? '0 : ssd_next;
    assign ssd_valid = !ctl.recon && ctl.last;

endmodule

@@ src/intra_prediction_residual_unit.sv @@
// Intra prediction residual unit: top level.
// A pixel request is registered in stage 1 with its reference memory read, then in the output register.
// Throughput: one request per cycle unless the output stalls; memory read, then one multiply-accumulate.
// Reference loads give no result.
// Reset (rst_n low, async): clears handshake state, config registers, and the SSD sum;
// reference memories are not cleared.
module intra_prediction_residual_unit import ipr_pkg::*; #(
    parameter int SIZE = SIZE_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ipr_pix_if.sink   pix_in,
    ipr_res_if.source res_out,
    ipr_cfg_if.sink   cfg
);

`include "intra_prediction_residual_unit_assert.svh"

    localparam int TAW = $clog2(SIZE + 1);
    localparam int LAW = $clog2(SIZE);

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the unit is idle; the unit does not enforce it.
    // ------------------------------------------------------------------
    mode_t mode_reg;
    logic  top_avail_reg;
    logic  left_avail_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_VERT;
            top_avail_reg  <= 1'b0;
            left_avail_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                CFG_MODE:       mode_reg       <= mode_t'(cfg.data[1:0]);
                CFG_TOP_AVAIL:  top_avail_reg  <= cfg.data[0];
                CFG_LEFT_AVAIL: left_avail_reg <= cfg.data[0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Stage 1 holds a pixel request whose references are
    // being read; the output register holds the finished result.
    // ------------------------------------------------------------------
    logic     s1_valid_reg;
    pix_ctl_t s1_ctl_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic     out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [SSD_W-1:0] out_ssd_reg;
    logic     out_ssd_valid_reg;
    logic [SSD_W-1:0] ssd_sum_reg;

    logic     out_free;
    logic     s1_move;
    logic     accept;
    logic     is_pix;
    action_t  act;

    assign out_free     = !out_valid_reg || res_out.ready;
    assign s1_move      = s1_valid_reg && out_free;
    assign pix_in.ready = !s1_valid_reg || out_free;
    assign accept       = pix_in.valid && pix_in.ready;
    assign act          = action_t'(pix_in.action);
    assign is_pix       = (act == ACT_PREDICT) || (act == ACT_RECON);

    // ------------------------------------------------------------------
    // Reference addressing. Vertical/average read above the column,
    // horizontal/average left of the row; the diagonal walks back along
    // the down-right line to whichever edge it meets first.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] top_idx;
    logic [POS_W-1:0] left_idx;
    logic             top_in;
    logic             left_in;
    logic             below_diag;
    pix_ctl_t         ctl_next;

    assign below_diag = pix_in.row > pix_in.col;

    always_comb
    begin
        if (mode_reg == MODE_DIAG)
        begin
            top_idx  = IDX_W'(pix_in.col - pix_in.row);
            left_idx = pix_in.row - pix_in.col - POS_W'(1);
        end
        else
        begin
            top_idx  = IDX_W'(pix_in.col) + IDX_W'(1);
            left_idx = pix_in.row;
        end
    end

    assign top_in  = 32'(top_idx) <= SIZE;
    assign left_in = 32'(left_idx) < SIZE;

    always_comb
    begin
        ctl_next.recon   = (act == ACT_RECON);
        ctl_next.first   = pix_in.first;
        ctl_next.last    = pix_in.last;
        ctl_next.sel     = PSEL_TOP;
        ctl_next.top_ok  = 1'b0;
        ctl_next.left_ok = 1'b0;
        case (mode_reg)
            MODE_VERT:
            begin
                ctl_next.top_ok = top_avail_reg && top_in;
            end
            MODE_HORZ:
            begin
                ctl_next.sel     = PSEL_LEFT;
                ctl_next.left_ok = left_avail_reg && left_in;
            end
            MODE_AVG:
            begin
                ctl_next.sel     = PSEL_AVG;
                ctl_next.top_ok  = top_avail_reg && top_in;
                ctl_next.left_ok = left_avail_reg && left_in;
            end
            MODE_DIAG:
            begin
                // Needs both edges; otherwise flat mid-gray.
                if (top_avail_reg && left_avail_reg)
                begin
                    if (below_diag)
                    begin
                        ctl_next.sel     = PSEL_LEFT;
                        ctl_next.left_ok = left_in;
                    end
                    else
                    begin
                        ctl_next.top_ok = top_in;
                    end
                end
            end
            default:
            begin
                ctl_next.top_ok = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Reference memories. Loads clamp the sample to 0..255 and drop
    // indexes beyond the store.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] load_data;
    logic             top_we;
    logic             left_we;
    logic [PIX_W-1:0] rd_top;
    logic [PIX_W-1:0] rd_left;

    assign load_data = pix_in.sample[SAMPLE_W-1] ? '0 : pix_in.sample[PIX_W-1:0];
    assign top_we    = accept && (act == ACT_LOAD_TOP) && (32'(pix_in.ref_index) <= SIZE);
    assign left_we   = accept && (act == ACT_LOAD_LEFT) && (32'(pix_in.ref_index) < SIZE);

    ipr_ref_store #(
        .SIZE (SIZE)
    ) u_ref_store (
        .clk          (clk),
        .top_we       (top_we),
        .left_we      (left_we),
        .wr_top_addr  (TAW'(pix_in.ref_index)),
        .wr_left_addr (LAW'(pix_in.ref_index)),
        .wr_data      (load_data),
        .rd_en        (accept && is_pix),
        .rd_top_addr  (TAW'(top_idx)),
        .rd_left_addr (LAW'(left_idx)),
        .rd_top       (rd_top),
        .rd_left      (rd_left)
    );

    // Stage 1 control and payload, aligned with the registered memory read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept && is_pix)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_pix)
        begin
            s1_ctl_reg    <= ctl_next;
            s1_sample_reg <= pix_in.sample;
        end
    end

    // ------------------------------------------------------------------
    // Arithmetic stage: prediction, residual/reconstruction, SSD.
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] calc_value;
    logic [SSD_W-1:0]          calc_ssd;
    logic                      calc_ssd_valid;
    logic [SSD_W-1:0]          ssd_sum_next;

    ipr_pix_calc u_pix_calc (
        .ctl       (s1_ctl_reg),
        .sample    (s1_sample_reg),
        .rd_top    (rd_top),
        .rd_left   (rd_left),
        .ssd_sum   (ssd_sum_reg),
        .value     (calc_value),
        .ssd       (calc_ssd),
        .ssd_valid (calc_ssd_valid),
        .ssd_next  (ssd_sum_next)
    );

    // Running sum only advances on predict requests.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssd_sum_reg <= '0;
        end
        else if (s1_move && !s1_ctl_reg.recon)
        begin
            ssd_sum_reg <= ssd_sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_value_reg     <= calc_value;
            out_ssd_reg       <= calc_ssd;
            out_ssd_valid_reg <= calc_ssd_valid;
        end
    end

    assign res_out.valid     = out_valid_reg;
    assign res_out.value     = out_value_reg;
    assign res_out.ssd       = out_ssd_reg;
    assign res_out.ssd_valid = out_ssd_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IPR_ASSERT_IMP(a_final_ssd_tracks_sum, res_out.valid && res_out.ssd_valid,
        res_out.ssd == ssd_sum_reg, "final ssd differs from the running sum")
    `IPR_ASSERT_IMP(a_stall_only_when_full, !pix_in.ready,
        s1_valid_reg && out_valid_reg && !res_out.ready, "input stalled with room free")
    `IPR_ASSERT_NXT(a_ssd_no_decrease, s1_move && !s1_ctl_reg.recon && !s1_ctl_reg.first,
        ssd_sum_reg >= $past(ssd_sum_reg), "ssd sum decreased without a first pixel")

endmodule
